[design/firlt_pkg.sv]
package firlt_pkg;

  // Defaults for the top-level parameters
  localparam int DEF_MAX_TAPS    = 64;
  localparam int DEF_SAMPLE_BITS = 16;

  // Fixed field widths
  localparam int COEF_BITS  = 16;
  localparam int FRAC_BITS  = 15;
  localparam int TAP_IDX_W  = 6;
  localparam int NUM_TAPS_W = 7;

  localparam logic [NUM_TAPS_W-1:0] NUM_TAPS_RESET = NUM_TAPS_W'(1);

  // Transaction kind carried on tuser
  localparam logic FUNC_FILTER = 1'b0;
  localparam logic FUNC_LOAD   = 1'b1;

  // Controller -> datapath commands
  typedef struct packed {
    logic clear;   // zero one entry of both stores
    logic load;    // write one coefficient
    logic push;    // write sample into delay line, restart accumulator
    logic issue;   // read one tap pair into the MAC pipeline
    logic round;   // round/saturate accumulator into result register
  } firlt_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic clr_last;    // clearing pass at last entry
    logic pipe_empty;  // no tap pair in flight
  } firlt_sts_t;

endpackage

[design/fir_filter_loadable_taps.sv]
// Channel   Dir  Handshake                 Payload
// --------  ---  ------------------------  ------------------------------------------
// cfg       in   cfg_we (no ready)         cfg_data = num_taps
// s_axis    in   s_axis_tvalid/tready      tuser = func; tdata = sample_in, tap_index,
//                                          tap_value, zero pad to whole bytes
// m_axis    out  m_axis_tvalid/tready      tdata = sample_out, zero pad to whole bytes
//
// Flow: a coefficient load is written to the store as it is accepted. A
//   sample transaction presents its result after one shared multiplier and
//   accumulator read the taps one per cycle, then the multiply, accumulate,
//   drain check and round steps; with zero taps only the drain check and
//   round run. The next transaction is taken from the cycle the result is presented.
// Reset: rst is synchronous. After it a clearing pass zeros every entry of
//   the delay line and coefficient store; s_axis_tready stays low until it
//   ends. Configuration writes are taken throughout.
// Stalls: the result sits in an output register, so new transactions are
//   accepted while it waits; a following sample holds in its round step
//   until m_axis_tready frees the register.
module fir_filter_loadable_taps
  import firlt_pkg::*;
#(
  parameter int MAX_TAPS    = DEF_MAX_TAPS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  // num_taps register
  input  logic                  cfg_we,
  input  logic [NUM_TAPS_W-1:0] cfg_data,
  // input transactions
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // low to high: sample_in, tap_index, tap_value, zero pad
  input  logic [((SAMPLE_BITS + TAP_IDX_W + COEF_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // bit 0: func (0 = filter sample, 1 = load coefficient)
  input  logic [0:0]            s_axis_tuser,
  // result transactions
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // low to high: sample_out, zero pad
  output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata
);

  localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;

  firlt_cmd_t cmd;
  firlt_sts_t sts;

  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic [TAP_IDX_W-1:0]          tap_index;
  logic signed [COEF_BITS-1:0]   tap_value;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  // Unpack the input transaction fields
  assign sample_in = s_axis_tdata[SAMPLE_BITS-1:0];
  assign tap_index = s_axis_tdata[SAMPLE_BITS +: TAP_IDX_W];
  assign tap_value = s_axis_tdata[SAMPLE_BITS + TAP_IDX_W +: COEF_BITS];

  assign m_axis_tdata = OUT_W'(unsigned'(sample_out));

  // Sequencer: clearing pass, tap walk, drain, round and output handshake
  firlt_ctrl #(
    .MAX_TAPS (MAX_TAPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_valid  (s_axis_tvalid),
    .s_ready  (s_axis_tready),
    .s_func   (s_axis_tuser[0]),
    .m_valid  (m_axis_tvalid),
    .m_ready  (m_axis_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Stores, MAC pipeline, rounding and the result register
  firlt_datapath #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .sample_in  (sample_in),
    .tap_index  (tap_index),
    .tap_value  (tap_value),
    .sample_out (sample_out)
  );

endmodule

[design/firlt_ctrl.sv]
module firlt_ctrl
  import firlt_pkg::*;
#(
  parameter int MAX_TAPS = DEF_MAX_TAPS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [NUM_TAPS_W-1:0] cfg_data,
  input  logic                  s_valid,
  output logic                  s_ready,
  input  logic                  s_func,
  output logic                  m_valid,
  input  logic                  m_ready,
  output firlt_cmd_t            cmd,
  input  firlt_sts_t            sts
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MAC   = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_ROUND = 3'd4;

  // Largest tap count the register can ask for, capped by the built depth
  localparam int TAPS_CAP = (MAX_TAPS < (2**NUM_TAPS_W - 1)) ? MAX_TAPS
                                                             : (2**NUM_TAPS_W - 1);

  logic [2:0]            state, state_next;
  logic [NUM_TAPS_W-1:0] num_taps;
  logic [NUM_TAPS_W-1:0] cnt, cnt_next;
  logic [NUM_TAPS_W-1:0] taps_used;
  logic                  out_valid, out_valid_next;
  logic                  s_fire;

  assign taps_used = (num_taps > NUM_TAPS_W'(TAPS_CAP)) ? NUM_TAPS_W'(TAPS_CAP) : num_taps;

  assign s_ready = (state == ST_IDLE);
  assign s_fire  = s_valid && s_ready;
  assign m_valid = out_valid;

  always_comb begin
    cmd       = '0;
    cmd.clear = (state == ST_CLEAR);
    cmd.load  = s_fire && (s_func == FUNC_LOAD);
    cmd.push  = s_fire && (s_func == FUNC_FILTER);
    cmd.issue = (state == ST_MAC);
    cmd.round = (state == ST_ROUND) && (!out_valid || m_ready);
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      ST_CLEAR: begin
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd.push) begin
          cnt_next   = taps_used;
          state_next = (taps_used == '0) ? ST_DRAIN : ST_MAC;
        end
      end
      ST_MAC: begin
        cnt_next = cnt - NUM_TAPS_W'(1);
        if (cnt == NUM_TAPS_W'(1)) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (sts.pipe_empty) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        if (cmd.round) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (m_ready) out_valid_next = 1'b0;
    if (cmd.round) out_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= '0;
      out_valid <= 1'b0;
      num_taps  <= NUM_TAPS_RESET;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
      if (cfg_we) num_taps <= cfg_data;
    end
  end

  a_mac_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MAC) |-> (cnt != '0))
    else $error("MAC issue with zero taps left");

  a_push_starts: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> ((state == ST_MAC) || (state == ST_DRAIN)))
    else $error("sample accepted without starting the MAC walk");

  a_result_from_round: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_ROUND))
    else $error("result presented outside the round step");

endmodule

[design/firlt_datapath.sv]
module firlt_datapath
  import firlt_pkg::*;
#(
  parameter int MAX_TAPS    = DEF_MAX_TAPS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  firlt_cmd_t                    cmd,
  output firlt_sts_t                    sts,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  input  logic [TAP_IDX_W-1:0]          tap_index,
  input  logic signed [COEF_BITS-1:0]   tap_value,
  output logic signed [SAMPLE_BITS-1:0] sample_out
);

  localparam int AW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W  = PROD_W + AW + 1;

  localparam logic [AW-1:0] LAST = AW'(MAX_TAPS - 1);

  localparam logic signed [ACC_W:0] RND    = (ACC_W+1)'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [ACC_W:0] SAT_HI =
    {{(ACC_W - SAMPLE_BITS + 2){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [ACC_W:0] SAT_LO = ~SAT_HI;

  logic signed [SAMPLE_BITS-1:0] delay_mem [MAX_TAPS];
  logic signed [COEF_BITS-1:0]   tap_mem   [MAX_TAPS];

  logic [AW-1:0] clr_addr;
  logic [AW-1:0] wp, wp_next;
  logic [AW-1:0] d_rd, t_rd;

  logic                          dly_we, tap_we, load_ok;
  logic [AW-1:0]                 dly_wa, tap_wa;
  logic signed [SAMPLE_BITS-1:0] dly_wd;
  logic signed [COEF_BITS-1:0]   tap_wd;

  logic signed [SAMPLE_BITS-1:0] d_q;
  logic signed [COEF_BITS-1:0]   c_q;
  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       acc;
  logic                          rd_v, mul_v;

  logic signed [ACC_W:0] rsum, rshift, rsat;

  assign wp_next = (wp == LAST) ? '0 : wp + AW'(1);
  assign load_ok = (32'(tap_index) < MAX_TAPS);

  // Store write ports; the clearing pass owns both after reset
  always_comb begin
    dly_we = cmd.clear || cmd.push;
    dly_wa = cmd.clear ? clr_addr : wp_next;
    dly_wd = cmd.clear ? '0 : sample_in;
    tap_we = cmd.clear || (cmd.load && load_ok);
    tap_wa = cmd.clear ? clr_addr : AW'(tap_index);
    tap_wd = cmd.clear ? '0 : tap_value;
  end

  always_ff @(posedge clk) begin
    if (dly_we) delay_mem[dly_wa] <= dly_wd;
    if (tap_we) tap_mem[tap_wa] <= tap_wd;
    if (cmd.issue) begin
      d_q <= delay_mem[d_rd];
      c_q <= tap_mem[t_rd];
    end
    prod <= d_q * c_q;
    if (cmd.push) begin
      acc <= '0;
    end else if (mul_v) begin
      acc <= acc + ACC_W'(prod);
    end
    if (cmd.round) sample_out <= rsat[SAMPLE_BITS-1:0];
  end

  // Read pointers: delay walks back from the newest sample, taps walk up from 0
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      d_rd <= wp_next;
      t_rd <= '0;
    end else if (cmd.issue) begin
      d_rd <= (d_rd == '0) ? LAST : d_rd - AW'(1);
      t_rd <= t_rd + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      wp       <= '0;
      rd_v     <= 1'b0;
      mul_v    <= 1'b0;
    end else begin
      if (cmd.clear) clr_addr <= clr_addr + AW'(1);
      if (cmd.push) wp <= wp_next;
      rd_v  <= cmd.issue;
      mul_v <= rd_v;
    end
  end

  // Round half up, then clamp to the sample range
  always_comb begin
    rsum   = (ACC_W+1)'(acc) + RND;
    rshift = rsum >>> FRAC_BITS;
    if (rshift > SAT_HI) begin
      rsat = SAT_HI;
    end else if (rshift < SAT_LO) begin
      rsat = SAT_LO;
    end else begin
      rsat = rshift;
    end
  end

  assign sts.clr_last   = (clr_addr == LAST);
  assign sts.pipe_empty = !rd_v && !mul_v;

  a_rd_follows_issue: assert property (@(posedge clk) disable iff (rst)
    rd_v |-> $past(cmd.issue))
    else $error("read stage valid without an issue");

  a_round_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.round |-> (!rd_v && !mul_v))
    else $error("rounding while products are still in flight");

endmodule
